// ===== rtl/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the max heap priority queue: widths, operation codes and the
// control word that the queue broadcasts to its row of cells.
// Depends on nothing; every other file of the block uses it.
package mhpq_pkg;

  // Field widths of the input and result words.
  localparam int KEY_W  = 31;
  localparam int MODE_W = 2;
  localparam int OCC_W  = 9;

  // Default number of keys the queue holds.
  localparam int CAPACITY_DEF = 256;

  // Operation codes carried in the mode field; the fourth code is a no-op.
  typedef enum logic [MODE_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Control word broadcast to every cell in the cycle an operation applies.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== rtl/mhpq_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the priority queue: valid/ready handshake with an
// operation code and a key. Depends on mhpq_pkg for the field widths.
interface mhpq_in_if;
  logic                         valid;
  logic                         ready;
  logic [mhpq_pkg::MODE_W-1:0]  mode;
  logic [mhpq_pkg::KEY_W-1:0]   key_in;

  modport source (output valid, output mode, output key_in, input ready);
  modport sink   (input valid, input mode, input key_in, output ready);
endinterface

// ===== rtl/mhpq_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the priority queue: valid/ready handshake with the
// popped key, two status flags and the occupancy. Depends on mhpq_pkg.
interface mhpq_out_if;
  logic                        valid;
  logic                        ready;
  logic [mhpq_pkg::KEY_W-1:0]  key_out;
  logic                        pop_empty;
  logic                        push_dropped;
  logic [mhpq_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output key_out, output pop_empty,
                  output push_dropped, output occupancy, input ready);
  modport sink   (input valid, input key_out, input pop_empty,
                  input push_dropped, input occupancy, output ready);
endinterface

// ===== rtl/mhpq_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted key row. The row is kept in descending order from
// cell 0; each cell looks at its left and right neighbors. Depends on mhpq_pkg.
module mhpq_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mhpq_pkg::cell_ctrl_t       ctrl,
  input  logic [mhpq_pkg::KEY_W-1:0] left_key,
  input  logic                       left_valid,
  input  logic                       left_ge,
  input  logic [mhpq_pkg::KEY_W-1:0] right_key,
  input  logic                       right_valid,
  output logic [mhpq_pkg::KEY_W-1:0] key,
  output logic                       valid,
  output logic                       ge
);

  logic [mhpq_pkg::KEY_W-1:0] key_r;
  logic [mhpq_pkg::KEY_W-1:0] key_nxt;
  logic                       valid_r;
  logic                       valid_nxt;

  // This cell keeps its key on a push when it holds one at least as large.
  assign ge    = valid_r && (key_r >= ctrl.key);
  assign key   = key_r;
  assign valid = valid_r;

  // Next contents: keep, clear, take the new key, shift right on push, shift left on pop.
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.pop) begin
      key_nxt   = right_key;
      valid_nxt = right_valid;
    end else if (ctrl.push && !ge) begin
      if (left_ge) begin
        key_nxt   = ctrl.key;
        valid_nxt = 1'b1;
      end else begin
        key_nxt   = left_key;
        valid_nxt = left_valid;
      end
    end
  end

  // Occupancy flag is control state and resets.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Key payload needs no reset.
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// Top level of the max priority queue: operation register, a row of
// CAPACITY sorted cells and the result register. Depends on mhpq_pkg,
// mhpq_in_if, mhpq_out_if and mhpq_cell.
//
//   channel  direction  word
//   in_ch    sink       mode (push, pop, clear), key_in
//   out_ch   source     key_out, pop_empty, push_dropped, occupancy
//
// Each operation waits in the operation register, then applies in a cycle
// in which every cell compares against the key and shifts at once.
// Any operation costs the same, whatever the occupancy.
// Reset (synchronous, rst_n low) empties the queue; key contents are not cleared.
// A stalled result holds the next operation in its register; a new word is
// taken only after the held operation has applied.
module max_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  mhpq_in_if.sink          in_ch,
  mhpq_out_if.source       out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Operation register.
  logic                         op_valid_r;
  logic                         op_valid_nxt;
  logic [mhpq_pkg::MODE_W-1:0]  op_mode_r;
  logic [mhpq_pkg::KEY_W-1:0]   op_key_r;

  // Queue occupancy.
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;

  // Result register.
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [mhpq_pkg::KEY_W-1:0]   key_out_r;
  logic [mhpq_pkg::KEY_W-1:0]   key_out_nxt;
  logic                         pop_empty_r;
  logic                         pop_empty_nxt;
  logic                         push_dropped_r;
  logic                         push_dropped_nxt;
  logic [mhpq_pkg::OCC_W-1:0]   occupancy_r;

  logic                         in_fire;
  logic                         apply;
  logic                         full;
  mhpq_pkg::cell_ctrl_t         ctrl;

  // Cell row wiring.
  logic [mhpq_pkg::KEY_W-1:0]   cell_key   [CAPACITY];
  logic                         cell_valid [CAPACITY];
  logic                         cell_ge    [CAPACITY];

  // Handshake: one operation in flight, applied when the result slot frees.
  assign in_ch.ready = !op_valid_r;
  assign in_fire     = in_ch.valid && !op_valid_r;
  assign apply       = op_valid_r && (!out_valid_r || out_ch.ready);
  assign full        = (count_r == CNT_W'(CAPACITY));

  // Decode the held operation into the cell control word and the result.
  always_comb begin
    ctrl             = '0;
    ctrl.key         = op_key_r;
    count_nxt        = count_r;
    key_out_nxt      = '0;
    pop_empty_nxt    = 1'b0;
    push_dropped_nxt = 1'b0;
    unique case (op_mode_r)
      mhpq_pkg::OP_PUSH: begin
        if (full) begin
          push_dropped_nxt = 1'b1;
        end else begin
          ctrl.push = apply;
          count_nxt = count_r + 1'b1;
        end
      end
      mhpq_pkg::OP_POP: begin
        if (count_r == '0) begin
          pop_empty_nxt = 1'b1;
        end else begin
          ctrl.pop    = apply;
          key_out_nxt = cell_key[0];
          count_nxt   = count_r - 1'b1;
        end
      end
      mhpq_pkg::OP_CLEAR: begin
        ctrl.clear = apply;
        count_nxt  = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // Valid flags of both registers.
  always_comb begin
    op_valid_nxt = op_valid_r;
    if (apply) begin
      op_valid_nxt = 1'b0;
    end else if (in_fire) begin
      op_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      op_valid_r  <= op_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (apply) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_mode_r <= in_ch.mode;
      op_key_r  <= in_ch.key_in;
    end
    if (apply) begin
      key_out_r      <= key_out_nxt;
      pop_empty_r    <= pop_empty_nxt;
      push_dropped_r <= push_dropped_nxt;
      occupancy_r    <= mhpq_pkg::OCC_W'(count_nxt);
    end
  end

  // Row of sorted cells, largest key in cell 0.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [mhpq_pkg::KEY_W-1:0] l_key;
    logic                       l_valid;
    logic                       l_ge;
    logic [mhpq_pkg::KEY_W-1:0] r_key;
    logic                       r_valid;

    if (i == 0) begin : g_head
      assign l_key   = '0;
      assign l_valid = 1'b1;
      assign l_ge    = 1'b1;
    end else begin : g_body
      assign l_key   = cell_key[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_ge    = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_key   = '0;
      assign r_valid = 1'b0;
    end else begin : g_link
      assign r_key   = cell_key[i+1];
      assign r_valid = cell_valid[i+1];
    end

    mhpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_key    (l_key),
      .left_valid  (l_valid),
      .left_ge     (l_ge),
      .right_key   (r_key),
      .right_valid (r_valid),
      .key         (cell_key[i]),
      .valid       (cell_valid[i]),
      .ge          (cell_ge[i])
    );
  end

  // Result channel.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.key_out      = key_out_r;
  assign out_ch.pop_empty    = pop_empty_r;
  assign out_ch.push_dropped = push_dropped_r;
  assign out_ch.occupancy    = occupancy_r;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for max_heap_priority_queue: a directed script, then random
// fill, drain and mixed traffic, checked against a behavioral queue model or pinned results.
// Depends on mhpq_pkg, mhpq_in_if, mhpq_out_if and the queue RTL.
module tb;

  localparam int DEPTH        = mhpq_pkg::CAPACITY_DEF;
  localparam int PHASE_ITEMS  = 467;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_TICKS = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  // The fourth mode code performs no operation.
  localparam logic [mhpq_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
  localparam logic [mhpq_pkg::KEY_W-1:0]  KEY_MAX  = {mhpq_pkg::KEY_W{1'b1}};

  // One result word as the queue reports it.
  typedef struct packed {
    logic [mhpq_pkg::KEY_W-1:0] key;
    logic                       empty;
    logic                       dropped;
    logic [mhpq_pkg::OCC_W-1:0] occ;
  } queue_result_t;

  // One directed word; a pinned row carries its result written out by hand.
  typedef struct {
    logic [mhpq_pkg::MODE_W-1:0] mode;
    logic [mhpq_pkg::KEY_W-1:0]  key;
    bit                          pinned;
    queue_result_t               res;
  } script_row_t;

  // Traffic shapes of the random part, visited in this order.
  typedef enum logic [1:0] {
    SEG_FILL,
    SEG_MIX_HIGH,
    SEG_DRAIN,
    SEG_MIX_LOW
  } segment_t;

  localparam queue_result_t NO_RES = '0;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic hold_rx = 1'b0;

  // Pinned expectation that travels with the offered word.
  logic          pinned_now = 1'b0;
  queue_result_t pinned_result = '0;

  mhpq_in_if  in_ch ();
  mhpq_out_if out_ch ();

  max_heap_priority_queue #(
    .CAPACITY(DEPTH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [mhpq_pkg::KEY_W-1:0] held_keys[$];
  queue_result_t              pending_results[$];
  int                         error_count = 0;
  int                         cycle_count = 0;
  int                         send_idle_pct = 0;
  int                         recv_idle_pct = 0;
  segment_t                   seg_kind = SEG_MIX_LOW;
  int                         seg_left = 0;
  queue_result_t              predicted;
  queue_result_t              wanted;

  script_row_t script [24] = '{
    '{mhpq_pkg::OP_POP,   '0,            1'b1, '{'0, 1'b1, 1'b0, 9'd0}},
    '{MODE_NOP,           KEY_MAX,       1'b1, '{'0, 1'b0, 1'b0, 9'd0}},
    '{mhpq_pkg::OP_CLEAR, '0,            1'b1, '{'0, 1'b0, 1'b0, 9'd0}},
    '{mhpq_pkg::OP_PUSH,  KEY_MAX,       1'b1, '{'0, 1'b0, 1'b0, 9'd1}},
    '{mhpq_pkg::OP_PUSH,  '0,            1'b1, '{'0, 1'b0, 1'b0, 9'd2}},
    '{mhpq_pkg::OP_PUSH,  31'h5555_5555, 1'b1, '{'0, 1'b0, 1'b0, 9'd3}},
    '{mhpq_pkg::OP_PUSH,  31'h2AAA_AAAA, 1'b1, '{'0, 1'b0, 1'b0, 9'd4}},
    '{mhpq_pkg::OP_PUSH,  KEY_MAX,       1'b1, '{'0, 1'b0, 1'b0, 9'd5}},
    '{MODE_NOP,           KEY_MAX,       1'b1, '{'0, 1'b0, 1'b0, 9'd5}},
    '{mhpq_pkg::OP_POP,   '0,            1'b1, '{KEY_MAX, 1'b0, 1'b0, 9'd4}},
    '{mhpq_pkg::OP_POP,   KEY_MAX,       1'b1, '{KEY_MAX, 1'b0, 1'b0, 9'd3}},
    '{mhpq_pkg::OP_POP,   '0,            1'b1, '{31'h5555_5555, 1'b0, 1'b0, 9'd2}},
    '{mhpq_pkg::OP_PUSH,  31'd1,         1'b0, NO_RES},
    '{mhpq_pkg::OP_PUSH,  31'h4000_0000, 1'b0, NO_RES},
    '{mhpq_pkg::OP_POP,   '0,            1'b0, NO_RES},
    '{mhpq_pkg::OP_CLEAR, KEY_MAX,       1'b1, '{'0, 1'b0, 1'b0, 9'd0}},
    '{mhpq_pkg::OP_POP,   '0,            1'b1, '{'0, 1'b1, 1'b0, 9'd0}},
    '{mhpq_pkg::OP_PUSH,  31'd5,         1'b0, NO_RES},
    '{mhpq_pkg::OP_PUSH,  31'd3,         1'b0, NO_RES},
    '{mhpq_pkg::OP_PUSH,  31'd9,         1'b0, NO_RES},
    '{mhpq_pkg::OP_POP,   '0,            1'b0, NO_RES},
    '{mhpq_pkg::OP_POP,   '0,            1'b0, NO_RES},
    '{mhpq_pkg::OP_POP,   '0,            1'b0, NO_RES},
    '{mhpq_pkg::OP_POP,   KEY_MAX,       1'b1, '{'0, 1'b1, 1'b0, 9'd0}}
  };

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one operation to the behavioral queue and returns its result.
  // Equal keys are interchangeable, so removing any copy of the largest is enough.
  function automatic queue_result_t apply_queue_op(logic [mhpq_pkg::MODE_W-1:0] mode,
                                                   logic [mhpq_pkg::KEY_W-1:0] key);
    queue_result_t r;
    int            top;
    r   = '0;
    top = 0;
    case (mode)
      mhpq_pkg::OP_PUSH: begin
        if (held_keys.size() >= DEPTH) r.dropped = 1'b1;
        else held_keys.push_back(key);
      end
      mhpq_pkg::OP_POP: begin
        if (held_keys.size() == 0) begin
          r.empty = 1'b1;
        end else begin
          for (int i = 1; i < held_keys.size(); i++) begin
            if (held_keys[i] > held_keys[top]) top = i;
          end
          r.key = held_keys[top];
          held_keys.delete(top);
        end
      end
      mhpq_pkg::OP_CLEAR: held_keys.delete();
      default: ;
    endcase
    r.occ = mhpq_pkg::OCC_W'(held_keys.size());
    return r;
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Picks the next operation following the current traffic shape.
  function automatic logic [mhpq_pkg::MODE_W-1:0] pick_mode();
    int roll;
    if (seg_left == 0) begin
      case (seg_kind)
        SEG_FILL:     seg_kind = SEG_MIX_HIGH;
        SEG_MIX_HIGH: seg_kind = SEG_DRAIN;
        SEG_DRAIN:    seg_kind = SEG_MIX_LOW;
        default:      seg_kind = SEG_FILL;
      endcase
      if (seg_kind == SEG_FILL || seg_kind == SEG_DRAIN) seg_left = $urandom_range(380, 300);
      else seg_left = $urandom_range(120, 30);
    end
    seg_left--;
    roll = $urandom_range(99);
    case (seg_kind)
      SEG_FILL: begin
        if (roll < 95) return mhpq_pkg::OP_PUSH;
        if (roll < 99) return mhpq_pkg::OP_POP;
        return MODE_NOP;
      end
      SEG_DRAIN: begin
        if (roll < 4) return mhpq_pkg::OP_PUSH;
        if (roll < 99) return mhpq_pkg::OP_POP;
        return MODE_NOP;
      end
      default: begin
        if (roll < 50) return mhpq_pkg::OP_PUSH;
        if (roll < 96) return mhpq_pkg::OP_POP;
        if (roll < 98) return mhpq_pkg::OP_CLEAR;
        return MODE_NOP;
      end
    endcase
  endfunction

  // Mostly uniform keys, with a narrow range for duplicates and the extremes.
  function automatic logic [mhpq_pkg::KEY_W-1:0] pick_key();
    int          roll;
    logic [31:0] raw;
    roll = $urandom_range(99);
    raw  = $urandom();
    if (roll < 60) return raw[mhpq_pkg::KEY_W-1:0];
    if (roll < 80) return mhpq_pkg::KEY_W'($urandom_range(15));
    case ($urandom_range(3))
      0:       return '0;
      1:       return KEY_MAX;
      2:       return mhpq_pkg::KEY_W'(1);
      default: return KEY_MAX - 1'b1;
    endcase
  endfunction

  // Offers one word after a random gap and returns once it has been taken.
  task automatic offer_word(logic [mhpq_pkg::MODE_W-1:0] mode,
                            logic [mhpq_pkg::KEY_W-1:0] key,
                            bit pinned, queue_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.key_in  <= key;
    pinned_now    <= pinned;
    pinned_result <= res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Holds the sender back until every expected word has come out.
  task automatic wait_for_quiet();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver: random back-pressure, forced low during a hold-off.
  always @(posedge clk) begin
    out_ch.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // Predicts on every accepted input word and checks every accepted result word.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predicted = apply_queue_op(in_ch.mode, in_ch.key_in);
      pending_results.push_back(pinned_now ? pinned_result : predicted);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected word key_out %h occupancy %0d",
                             out_ch.key_out, out_ch.occupancy));
      end else begin
        wanted = pending_results.pop_front();
        if (out_ch.key_out !== wanted.key)
          flag_error($sformatf("key_out expected %h, got %h", wanted.key, out_ch.key_out));
        if (out_ch.pop_empty !== wanted.empty)
          flag_error($sformatf("pop_empty expected %b, got %b", wanted.empty,
                               out_ch.pop_empty));
        if (out_ch.push_dropped !== wanted.dropped)
          flag_error($sformatf("push_dropped expected %b, got %b", wanted.dropped,
                               out_ch.push_dropped));
        if (out_ch.occupancy !== wanted.occ)
          flag_error($sformatf("occupancy expected %0d, got %0d", wanted.occ,
                               out_ch.occupancy));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.mode   = mhpq_pkg::OP_PUSH;
    in_ch.key_in = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script with steady handshakes.
    foreach (script[i]) begin
      offer_word(script[i].mode, script[i].key, script[i].pinned, script[i].res);
    end

    // Random traffic in three idling regimes; the last one opens with a long hold-off.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_for_quiet();
      if (ph == 2) begin
        fork
          begin
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx <= 1'b0;
          end
        join_none
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        offer_word(pick_mode(), pick_key(), 1'b0, NO_RES);
      end
    end

    wait_for_quiet();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
